// ----- rtl/ptbma_pkg.sv -----
// shared types and constants for the per-track box moving average
package ptbma_pkg;

    localparam int unsigned WinResetVal = 5;

    // history ring length per track, a power of two
    localparam int unsigned HistoryDepth = 8;

    typedef struct packed {
        logic               opcode;
        logic        [15:0] target_id;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic        [14:0] box_w;
        logic        [14:0] box_h;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] smooth_x;
        logic signed [15:0] smooth_y;
        logic        [14:0] smooth_w;
        logic        [14:0] smooth_h;
        logic               table_full;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EOF,
        S_SRCH,
        S_WRITE,
        S_SUMRD,
        S_SUMACC,
        S_DIV,
        S_OUT
    } t_state;

    // start request for the shared divider
    typedef struct packed {
        logic        start;
        logic [22:0] mag;
        logic        neg;
    } t_div_req;

endpackage

// ----- rtl/ptbma_ram.sv -----
// generic single-port-write ram with registered read
module ptbma_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/ptbma_div.sv -----
// shared restoring divider with round half away from zero
module ptbma_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ptbma_pkg::t_div_req     i_req,
    input  logic [3:0]              i_n,
    output logic                    o_done,
    output logic signed [23:0]      o_quot
);
    import ptbma_pkg::*;

    // dividend 2*mag+n fits 25 bits, divisor 2n fits 5 bits
    logic [24:0] r_num, n_num;
    logic [4:0]  r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_neg;
    logic [5:0]  w_trial;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_num[24]};
        if (i_req.start) begin
            n_num  = {1'b0, i_req.mag, 1'b0} + {21'd0, i_n};
            n_rem  = '0;
            n_cnt  = 5'd25;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // one quotient bit per cycle
            n_num = {r_num[23:0], 1'b0};
            if (w_trial >= {1'b0, i_n, 1'b0}) begin
                n_rem    = 5'(w_trial - {1'b0, i_n, 1'b0});
                n_num[0] = 1'b1;
            end else begin
                n_rem = w_trial[4:0];
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_req.start) begin
            r_neg <= i_req.neg;
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    // final quotient is visible in r_num in the cycle after done
    assign o_quot = r_neg ? -$signed({1'b0, r_num[22:0]}) : $signed({1'b0, r_num[22:0]});
endmodule

// ----- rtl/per_track_box_moving_average_top.sv -----
// top level: track table, history memories, sequencer
// Per-track box moving average. A box transaction searches the track table one
// slot per cycle, writes the box into its history ring, reads back the n
// averaged entries one per cycle (one history ram read port), then runs the
// four averages through one shared 25-step serial divider, so n and MAX_TRACKS
// set the time per box. The result becomes valid in the same cycle as the block
// is ready again. A box that finds the table full returns once the search ends.
// An end-of-frame transaction frees the unseen tracks in its S_EOF state,
// returns nothing, and the block is ready again once that state is done. The
// block is not ready while a transaction is in flight; a finished result waits
// in an output register, so the next transaction can start while it is held.
module per_track_box_moving_average_top #(
    parameter int unsigned MAX_TRACKS    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ptbma_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ptbma_pkg::t_out_item o_data,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_data
);
    import ptbma_pkg::*;

    localparam int unsigned SW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int unsigned HW = $clog2(HistoryDepth);
    localparam int unsigned AW = SW + HW;
    localparam int unsigned FW = $clog2(HistoryDepth + 1);

    t_state r_state, n_state;

    logic [3:0]  r_win;
    logic [MAX_TRACKS-1:0] r_valid, r_seen;
    logic [15:0] r_track [MAX_TRACKS];
    logic [FW-1:0] r_fill [MAX_TRACKS];
    logic [HW-1:0] r_head [MAX_TRACKS];

    t_in_item  r_in;
    t_out_item r_res;
    t_out_item r_out;
    logic      r_oval;
    logic [SW:0] r_idx;
    logic [SW-1:0] r_slot;
    logic        r_hit, r_free_ok;
    logic [SW-1:0] r_free;
    logic [3:0]  r_n;
    logic [3:0]  r_i;
    logic [HW-1:0] r_pos;
    logic        r_rdv;
    logic signed [22:0] r_sx, r_sy, r_sw, r_sh;
    logic [1:0]  r_fsel;
    logic        r_dstart;

    logic [3:0]  w_eff;
    logic [SW-1:0] w_i;
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0] w_rx, w_ry;
    logic [14:0] w_rw, w_rh;
    logic        w_ddone;
    logic signed [23:0] w_q;
    logic        r_qv;
    t_div_req    w_req;
    logic signed [22:0] w_sel;

    assign w_i   = r_idx[SW-1:0];
    assign w_eff = (r_win == 4'd0) ? 4'd1 :
                   ((r_win > 4'(HistoryDepth)) ? 4'(HistoryDepth) : r_win);

    // history memories
    assign w_we    = (r_state == S_WRITE);
    assign w_waddr = {r_slot, r_head[r_slot]};
    assign w_raddr = {r_slot, r_pos};

    ptbma_ram #(.WIDTH(16), .DEPTH(MAX_TRACKS*HistoryDepth)) u_hx (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_in.box_x),
        .i_raddr(w_raddr), .o_rdata(w_rx));
    ptbma_ram #(.WIDTH(16), .DEPTH(MAX_TRACKS*HistoryDepth)) u_hy (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_in.box_y),
        .i_raddr(w_raddr), .o_rdata(w_ry));
    ptbma_ram #(.WIDTH(15), .DEPTH(MAX_TRACKS*HistoryDepth)) u_hw (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_in.box_w),
        .i_raddr(w_raddr), .o_rdata(w_rw));
    ptbma_ram #(.WIDTH(15), .DEPTH(MAX_TRACKS*HistoryDepth)) u_hh (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_in.box_h),
        .i_raddr(w_raddr), .o_rdata(w_rh));

    // divider operand select
    always_comb begin
        case (r_fsel)
            2'd0:    w_sel = r_sx;
            2'd1:    w_sel = r_sy;
            2'd2:    w_sel = r_sw;
            default: w_sel = r_sh;
        endcase
    end
    assign w_req.start = r_dstart;
    assign w_req.neg   = w_sel[22];
    assign w_req.mag   = w_sel[22] ? 23'(-w_sel) : 23'(w_sel);

    ptbma_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .i_n(r_n),
        .o_done(w_ddone), .o_quot(w_q));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = i_data.opcode ? S_EOF : S_SRCH;
                end
            end
            S_EOF:  n_state = S_IDLE;
            S_SRCH: begin
                if (r_idx == (SW+1)'(MAX_TRACKS)) begin
                    n_state = (r_hit || r_free_ok) ? S_WRITE : S_OUT;
                end
            end
            S_WRITE:  n_state = S_SUMRD;
            S_SUMRD:  n_state = (r_i == r_n) ? S_SUMACC : S_SUMRD;
            S_SUMACC: n_state = S_DIV;
            S_DIV: begin
                if (r_qv && r_fsel == 2'd3) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:    n_state = (!r_oval || i_ready) ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = r_oval;
        o_data  = r_out;
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_win    <= 4'(WinResetVal);
            r_valid  <= '0;
            r_seen   <= '0;
            r_oval   <= 1'b0;
            r_dstart <= 1'b0;
            r_qv     <= 1'b0;
            for (int k = 0; k < MAX_TRACKS; k++) begin
                r_fill[k] <= '0;
                r_head[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_dstart <= 1'b0;
            r_qv     <= w_ddone;
            if (i_cfg_we) begin
                r_win <= i_cfg_data;
            end
            // output register, refilled once the held result leaves
            if (r_state == S_OUT && (!r_oval || i_ready)) begin
                r_oval <= 1'b1;
                r_out  <= r_res;
            end else if (o_valid && i_ready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in      <= i_data;
                        r_idx     <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                    end
                end
                S_EOF: begin
                    for (int k = 0; k < MAX_TRACKS; k++) begin
                        if (r_valid[k] && !r_seen[k]) begin
                            r_valid[k] <= 1'b0;
                            r_fill[k]  <= '0;
                            r_head[k]  <= '0;
                        end
                    end
                    r_seen <= '0;
                end
                S_SRCH: begin
                    // one slot per cycle
                    if (r_idx != (SW+1)'(MAX_TRACKS)) begin
                        if (r_valid[w_i] && r_track[w_i] == r_in.target_id && !r_hit) begin
                            r_hit  <= 1'b1;
                            r_slot <= w_i;
                        end
                        if (!r_valid[w_i] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= w_i;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_hit && r_free_ok) begin
                        r_slot          <= r_free;
                        r_valid[r_free] <= 1'b1;
                        r_track[r_free] <= r_in.target_id;
                        r_fill[r_free]  <= '0;
                        r_head[r_free]  <= '0;
                    end else if (!r_hit) begin
                        r_res.smooth_x   <= r_in.box_x;
                        r_res.smooth_y   <= r_in.box_y;
                        r_res.smooth_w   <= (r_in.box_w == 15'd0) ? 15'd1 : r_in.box_w;
                        r_res.smooth_h   <= (r_in.box_h == 15'd0) ? 15'd1 : r_in.box_h;
                        r_res.table_full <= 1'b1;
                    end
                end
                S_WRITE: begin
                    r_seen[r_slot] <= 1'b1;
                    r_head[r_slot] <= HW'((HW+1)'(r_head[r_slot]) + 1'b1);
                    r_pos          <= r_head[r_slot];
                    if (4'(r_fill[r_slot]) + 4'd1 > w_eff) begin
                        r_n            <= w_eff;
                        r_fill[r_slot] <= FW'(w_eff);
                    end else begin
                        r_n            <= 4'(r_fill[r_slot]) + 4'd1;
                        r_fill[r_slot] <= r_fill[r_slot] + 1'b1;
                    end
                    r_i   <= '0;
                    r_rdv <= 1'b0;
                    r_sx  <= '0;
                    r_sy  <= '0;
                    r_sw  <= '0;
                    r_sh  <= '0;
                end
                S_SUMRD, S_SUMACC: begin
                    // one history entry per cycle, read registered
                    if (r_rdv) begin
                        r_sx <= r_sx + 23'(signed'(w_rx));
                        r_sy <= r_sy + 23'(signed'(w_ry));
                        r_sw <= r_sw + 23'(w_rw);
                        r_sh <= r_sh + 23'(w_rh);
                    end
                    r_rdv <= (r_state == S_SUMRD) && (r_i != r_n);
                    if (r_state == S_SUMRD && r_i != r_n) begin
                        r_i   <= r_i + 4'd1;
                        r_pos <= r_pos - 1'b1;
                    end
                    if (r_state == S_SUMACC) begin
                        r_fsel   <= 2'd0;
                        r_dstart <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_qv) begin
                        unique case (r_fsel)
                            2'd0: r_res.smooth_x <= w_q[15:0];
                            2'd1: r_res.smooth_y <= w_q[15:0];
                            2'd2: r_res.smooth_w <= (w_q < 24'sd1) ? 15'd1 : w_q[14:0];
                            default: r_res.smooth_h <= (w_q < 24'sd1) ? 15'd1 : w_q[14:0];
                        endcase
                        if (r_fsel != 2'd3) begin
                            r_fsel   <= r_fsel + 2'd1;
                            r_dstart <= 1'b1;
                        end
                        r_res.table_full <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- bench/per_track_box_moving_average_top_test.sv -----
// testbench for the per-track box moving average: directed table and table overflow, then random tracks
`timescale 1ns / 100ps

module per_track_box_moving_average_top_test;
    import ptbma_pkg::*;

    localparam int Tracks = 32;
    localparam int Depth = 8;
    localparam int WatchLimit = 20000;
    localparam int FinalWait = 400;
    localparam logic OpBox = 1'b0;
    localparam logic OpFrameEnd = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in_item i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out_item o_data;
    logic i_cfg_we = 1'b0;
    logic [3:0] i_cfg_data = '0;

    per_track_box_moving_average_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state: track table and history rings
    logic [3:0] win_reg;
    logic slot_used [Tracks];
    logic [15:0] slot_id [Tracks];
    logic slot_hit [Tracks];
    int slot_cnt [Tracks];
    int slot_wr [Tracks];
    int ring_x [Tracks][Depth];
    int ring_y [Tracks][Depth];
    int ring_w [Tracks][Depth];
    int ring_h [Tracks][Depth];

    t_out_item box_queue [$];
    int errors = 0;
    bit stall_hold = 1'b0;
    bit quiet_mode = 1'b0;
    int idle_cycles = 0;

    function automatic int avg_round(input int sum, input int n);
        int mag;
        int q;
        mag = (sum < 0) ? -sum : sum;
        q = (2 * mag + n) / (2 * n);
        return (sum < 0) ? -q : q;
    endfunction

    // field by field compare of one result
    function automatic void check_item(input t_out_item e, input t_out_item a);
        if (a.smooth_x !== e.smooth_x) begin
            $error("smooth_x exp %0d got %0d", e.smooth_x, a.smooth_x); errors++;
        end
        if (a.smooth_y !== e.smooth_y) begin
            $error("smooth_y exp %0d got %0d", e.smooth_y, a.smooth_y); errors++;
        end
        if (a.smooth_w !== e.smooth_w) begin
            $error("smooth_w exp %0d got %0d", e.smooth_w, a.smooth_w); errors++;
        end
        if (a.smooth_h !== e.smooth_h) begin
            $error("smooth_h exp %0d got %0d", e.smooth_h, a.smooth_h); errors++;
        end
        if (a.table_full !== e.table_full) begin
            $error("table_full exp %0d got %0d", e.table_full, a.table_full);
            errors++;
        end
    endfunction

    // computes the smoothed box for a transaction and updates the table
    function automatic void predict_box(input t_in_item it);
        int s;
        int n;
        int win;
        int pos;
        int sx, sy, sw, sh;
        t_out_item r;
        if (it.opcode == OpFrameEnd) begin
            for (int i = 0; i < Tracks; i++) begin
                if (slot_used[i] && !slot_hit[i]) begin
                    slot_used[i] = 1'b0;
                    slot_cnt[i] = 0;
                    slot_wr[i] = 0;
                end
                slot_hit[i] = 1'b0;
            end
            return;
        end
        s = -1;
        for (int i = 0; i < Tracks; i++)
            if (s < 0 && slot_used[i] && slot_id[i] == it.target_id) s = i;
        if (s < 0) begin
            for (int i = 0; i < Tracks; i++)
                if (s < 0 && !slot_used[i]) s = i;
            if (s < 0) begin
                r.smooth_x = it.box_x;
                r.smooth_y = it.box_y;
                r.smooth_w = (it.box_w == 0) ? 15'd1 : it.box_w;
                r.smooth_h = (it.box_h == 0) ? 15'd1 : it.box_h;
                r.table_full = 1'b1;
                box_queue.push_back(r);
                return;
            end
            slot_used[s] = 1'b1;
            slot_id[s] = it.target_id;
            slot_cnt[s] = 0;
            slot_wr[s] = 0;
        end
        slot_hit[s] = 1'b1;
        ring_x[s][slot_wr[s]] = int'(it.box_x);
        ring_y[s][slot_wr[s]] = int'(it.box_y);
        ring_w[s][slot_wr[s]] = int'(it.box_w);
        ring_h[s][slot_wr[s]] = int'(it.box_h);
        slot_wr[s] = (slot_wr[s] + 1) % Depth;
        win = (win_reg < 1) ? 1 : (win_reg > Depth) ? Depth : win_reg;
        n = (slot_cnt[s] + 1 > win) ? win : slot_cnt[s] + 1;
        slot_cnt[s] = n;
        sx = 0; sy = 0; sw = 0; sh = 0;
        for (int i = 0; i < n; i++) begin
            pos = (slot_wr[s] + Depth - 1 - i) % Depth;
            sx += ring_x[s][pos];
            sy += ring_y[s][pos];
            sw += ring_w[s][pos];
            sh += ring_h[s][pos];
        end
        sw = avg_round(sw, n);
        sh = avg_round(sh, n);
        r.smooth_x = 16'(avg_round(sx, n));
        r.smooth_y = 16'(avg_round(sy, n));
        r.smooth_w = (sw < 1) ? 15'd1 : 15'(sw);
        r.smooth_h = (sh < 1) ? 15'd1 : 15'(sh);
        r.table_full = 1'b0;
        box_queue.push_back(r);
    endfunction

    function automatic t_in_item make_box(input logic [15:0] id, input int x, input int y,
                                          input int w, input int h);
        t_in_item it;
        it.opcode = OpBox;
        it.target_id = id;
        it.box_x = 16'(x);
        it.box_y = 16'(y);
        it.box_w = 15'(w);
        it.box_h = 15'(h);
        return it;
    endfunction

    function automatic t_in_item frame_end();
        t_in_item it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.opcode = OpFrameEnd;
        return it;
    endfunction

    // send one transaction, predicting on acceptance
    task automatic send_item(input t_in_item it);
        if (!quiet_mode && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 34);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_box(it);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (box_queue.size() != 0) @(posedge i_clk);
        repeat (FinalWait) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [3:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_reg = v;
    endtask

    // receiver: random stalls, a held-off stretch, or always ready in quiet mode
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_hold) i_ready <= 1'b0;
        else if (quiet_mode) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 34);
    end

    // result check against oldest expected transaction
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && i_ready) begin
            if (box_queue.size() == 0) begin
                $error("result with nothing expected: %h", o_data);
                errors++;
            end else begin
                e = box_queue[0];
                box_queue.delete(0);
                check_item(e, o_data);
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    typedef struct {
        t_in_item item;
        bit known;
        t_out_item want;
    } t_row;

    t_row dir_rows [$];

    function automatic void add_row(input t_in_item it, input bit known, input t_out_item w);
        t_row r;
        r.item = it;
        r.known = known;
        r.want = w;
        dir_rows.push_back(r);
    endfunction

    // random boxes with mostly live ids, and some frame ends
    task automatic random_phase(input int count, input int id_span);
        t_in_item it;
        logic [95:0] raw;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8) it = frame_end();
            else begin
                raw = {$urandom, $urandom, $urandom};
                it = raw[$bits(t_in_item)-1:0];
                it.opcode = OpBox;
                if ($urandom_range(99) < 85) it.target_id = 16'($urandom_range(id_span - 1));
                if ($urandom_range(3) == 0) begin
                    it.box_w = 15'($urandom_range(3));
                    it.box_h = 15'($urandom_range(3));
                end
            end
            send_item(it);
        end
    endtask

    initial begin
        t_out_item w;
        t_out_item z;
        win_reg = 4'(WinResetVal);
        for (int i = 0; i < Tracks; i++) begin
            slot_used[i] = 1'b0; slot_hit[i] = 1'b0; slot_cnt[i] = 0; slot_wr[i] = 0;
            slot_id[i] = '0;
        end
        z = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: first box of a track passes itself after reset, with a zero size raised to one
        w = '{smooth_x: 16'sh8000, smooth_y: 16'sh7fff, smooth_w: 15'h7fff,
              smooth_h: 15'd1, table_full: 1'b0};
        add_row(make_box(16'hffff, -32768, 32767, 32767, 0), 1'b1, w);
        add_row(make_box(16'hffff, -32768, 32767, 32767, 0), 1'b0, z);
        add_row(make_box(16'hffff, 32767, -32768, 0, 32767), 1'b0, z);
        w = '{smooth_x: 16'sd0, smooth_y: 16'sd0, smooth_w: 15'd1,
              smooth_h: 15'd1, table_full: 1'b0};
        add_row(make_box(16'h0000, 0, 0, 0, 0), 1'b1, w);
        add_row(make_box(16'h0000, -1, 1, 1, 2), 1'b0, z);
        add_row(make_box(16'h0000, -2, 3, 2, 1), 1'b0, z);
        add_row(make_box(16'h0000, -3, 5, 3, 0), 1'b0, z);
        add_row(make_box(16'h0000, -4, 7, 4, 7), 1'b0, z);
        add_row(make_box(16'h0000, -5, 9, 5, 9), 1'b0, z);
        add_row(frame_end(), 1'b0, z);
        add_row(make_box(16'h0000, 7, -7, 7, 7), 1'b0, z);
        add_row(frame_end(), 1'b0, z);
        add_row(make_box(16'hffff, 100, 100, 10, 10), 1'b0, z);
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item);
            if (dir_rows[i].known) check_item(dir_rows[i].want, box_queue[$]);
        end

        // fill the table, then overflow it
        for (int i = 0; i < Tracks + 3; i++)
            send_item(make_box(16'(1000 + i), -i * 77, i * 91, i, 0));
        send_item(frame_end());
        send_item(frame_end());
        drain_results();

        // window settings, extremes and out of range
        write_window(4'd1);
        random_phase(150, 8);
        drain_results();
        write_window(4'd8);
        random_phase(200, 12);

        // hold the receiver off while boxes keep coming
        stall_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                stall_hold = 1'b0;
            end
            random_phase(6, 4);
        join
        drain_results();
        write_window(4'd0);
        random_phase(100, 6);
        drain_results();
        write_window(4'd15);
        random_phase(150, 40);
        drain_results();
        write_window(4'd3);
        quiet_mode = 1'b1;
        random_phase(120, 10);
        quiet_mode = 1'b0;
        drain_results();
        write_window(4'd6);
        random_phase(230, 20);

        drain_results();
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
